>>> design/ksem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksem_pkg: shared types and constants of the sorted event merge
// Field widths, operation and status codes, sequencer states and the
// control structs passed between the merge submodules.
// ----------------------------------------------------------------------------
package ksem_pkg;

    localparam int STREAMS_DEF = 4;
    localparam int DEPTH_DEF   = 16;

    localparam int TIME_W   = 32;
    localparam int TARGET_W = 32;
    localparam int WEIGHT_W = 32;
    localparam int STRM_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_LAST,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]   ev_time;
        logic [TARGET_W-1:0] ev_target;
        logic [WEIGHT_W-1:0] ev_weight;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // queue table commands
    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

    // queue table status of the selected stream
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // true when event a orders strictly before event b
    function automatic logic ev_less(input entry_t a, input entry_t b);
        logic lt;
        if (a.ev_time != b.ev_time)
        begin
            lt = a.ev_time < b.ev_time;
        end
        else
        begin
            lt = a.ev_target < b.ev_target;
        end
        return lt;
    endfunction

endpackage

>>> design/ksem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksem_if: valid/ready channels of the sorted event merge
// Input channel carries push/pop commands, output channel carries results.
// ----------------------------------------------------------------------------
interface ksem_in_if
    import ksem_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                func;
    logic [STRM_W-1:0]   stream;
    logic [TIME_W-1:0]   event_time;
    logic [TARGET_W-1:0] event_target;
    logic [WEIGHT_W-1:0] event_weight;

    modport source (
        output valid, func, stream, event_time, event_target, event_weight,
        input  ready
    );
    modport sink (
        input  valid, func, stream, event_time, event_target, event_weight,
        output ready
    );
endinterface

interface ksem_out_if
    import ksem_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   out_time;
    logic [TARGET_W-1:0] out_target;
    logic [WEIGHT_W-1:0] out_weight;
    logic [STRM_W-1:0]   out_stream;

    modport source (
        output valid, status, out_time, out_target, out_weight, out_stream,
        input  ready
    );
    modport sink (
        input  valid, status, out_time, out_target, out_weight, out_stream,
        output ready
    );
endinterface

>>> design/ksem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksem_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ksem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ksem_qtab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksem_qtab: per-stream FIFO bookkeeping
// Holds read pointer and fill count of each stream and turns the selected
// stream's head and tail positions into event store addresses.
// ----------------------------------------------------------------------------
module ksem_qtab
    import ksem_pkg::*;
#(
    parameter int STREAMS = STREAMS_DEF,
    parameter int DEPTH   = DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(STREAMS)-1:0]         idx,
    input  qctl_t                              ctl,
    output qstat_t                             stat,
    output logic [$clog2(STREAMS*DEPTH)-1:0]   head_addr,
    output logic [$clog2(STREAMS*DEPTH)-1:0]   tail_addr
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(STREAMS * DEPTH);

    logic [PTR_W-1:0] rp_reg [STREAMS];
    logic [CNT_W-1:0] fc_reg [STREAMS];

    logic [PTR_W-1:0]  head_pos;
    logic [CNT_W-1:0]  fill;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail_pos;
    logic [ADDR_W-1:0] base;
    logic [PTR_W-1:0]  head_adv;

    assign head_pos = rp_reg[idx];
    assign fill     = fc_reg[idx];
    assign tail_sum = SUM_W'(head_pos) + SUM_W'(fill);

    // wrap the tail modulo the FIFO depth
    always_comb
    begin
        if (tail_sum >= SUM_W'(DEPTH))
        begin
            tail_pos = PTR_W'(tail_sum - SUM_W'(DEPTH));
        end
        else
        begin
            tail_pos = PTR_W'(tail_sum);
        end
    end

    assign head_adv  = (head_pos == PTR_W'(DEPTH - 1)) ? '0 : head_pos + 1'b1;
    assign base      = ADDR_W'(idx) * ADDR_W'(DEPTH);
    assign head_addr = base + ADDR_W'(head_pos);
    assign tail_addr = base + ADDR_W'(tail_pos);

    assign stat.empty = (fill == '0);
    assign stat.full  = (fill >= CNT_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STREAMS; i++)
            begin
                rp_reg[i] <= '0;
                fc_reg[i] <= '0;
            end
        end
        else if (ctl.push)
        begin
            fc_reg[idx] <= fill + 1'b1;
        end
        else if (ctl.pop)
        begin
            rp_reg[idx] <= head_adv;
            fc_reg[idx] <= fill - 1'b1;
        end
    end

endmodule

>>> design/ksem_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksem_cmp: shared head comparator
// Takes one stream head per cycle and keeps the least event seen so far.
// ----------------------------------------------------------------------------
module ksem_cmp
    import ksem_pkg::*;
#(
    parameter int STREAMS = STREAMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       cand_vld,
    input  logic [$clog2(STREAMS)-1:0] cand_idx,
    input  entry_t                     cand,
    output logic                       found,
    output logic [$clog2(STREAMS)-1:0] best_idx,
    output entry_t                     best
);

    localparam int SIDX_W = $clog2(STREAMS);

    logic              found_reg;
    logic [SIDX_W-1:0] best_idx_reg;
    entry_t            best_reg;
    logic              take;

    // strict less keeps the lower stream on a full tie, as heads arrive in order
    assign take = cand_vld && (!found_reg || ev_less(cand, best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cand_idx;
            best_reg     <= cand;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule

>>> design/kway_sorted_event_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_sorted_event_merge: k-way merge of time-sorted event streams
// Per-stream FIFOs in one event store; a pop scans the heads and returns
// the least event by time, then target, then stream index.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one command per beat: func push appends the event to the
//          FIFO of the named stream, func pop removes the least head event.
//   out_ch returns exactly one result beat per command: status ok, full
//          (stream full or out of range) or empty, plus the popped event.
//   A push loads the result register from S_PUSH, and the sequencer then
//   returns to S_IDLE; a pop goes through S_SCAN, S_LAST and S_COMMIT:
//   one store read per stream, one step for the last compare, the commit.
//   The single read port and the one shared comparator set the pop time.
//   in_ready is high only while the
//   sequencer is idle, so one command is in flight at a time.
//   The result register frees in_ready as soon as it is loaded: the next
//   command is taken while a result still waits. If out_ch stalls, the
//   next command holds in its final step with no state change until the
//   result register frees.
//   Reset clears all read pointers and fill counts; the event store holds
//   no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module kway_sorted_event_merge
    import ksem_pkg::*;
#(
    parameter int STREAMS = STREAMS_DEF,
    parameter int DEPTH   = DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ksem_in_if.sink       in_ch,
    ksem_out_if.source    out_ch
);

    localparam int SIDX_W = $clog2(STREAMS);
    localparam int ADDR_W = $clog2(STREAMS * DEPTH);

    state_t state_reg, state_next;

    logic [SIDX_W-1:0] idx_reg, idx_next;
    logic              range_err_reg;
    entry_t            entry_reg;
    logic              rd_vld_reg;
    logic [SIDX_W-1:0] rd_idx_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    entry_t              out_entry_reg;
    logic [STRM_W-1:0]   out_stream_reg;

    logic in_fire;
    logic slot_free;

    qctl_t             q_ctl;
    qstat_t            q_stat;
    logic [SIDX_W-1:0] tab_idx;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] tail_addr;

    logic              ram_we;
    logic              ram_re;
    entry_t            ram_rdata;

    logic              cmp_clear;
    logic              best_found;
    logic [SIDX_W-1:0] best_idx;
    entry_t            best;

    logic              out_load;
    status_t           out_status;
    logic              out_take_best;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign tab_idx     = (state_reg == S_COMMIT) ? best_idx : idx_reg;

    ksem_qtab #(
        .STREAMS (STREAMS),
        .DEPTH   (DEPTH)
    ) u_qtab (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx       (tab_idx),
        .ctl       (q_ctl),
        .stat      (q_stat),
        .head_addr (head_addr),
        .tail_addr (tail_addr)
    );

    ksem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STREAMS * DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_addr),
        .wdata (entry_reg),
        .re    (ram_re),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    ksem_cmp #(
        .STREAMS (STREAMS)
    ) u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cmp_clear),
        .cand_vld (rd_vld_reg),
        .cand_idx (rd_idx_reg),
        .cand     (ram_rdata),
        .found    (best_found),
        .best_idx (best_idx),
        .best     (best)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_ch.func == FUNC_POP) ? S_SCAN : S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == SIDX_W'(STREAMS - 1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_ctl         = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        cmp_clear     = 1'b0;
        out_load      = 1'b0;
        out_status    = ST_OK;
        out_take_best = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmp_clear = in_fire;
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (range_err_reg || q_stat.full)
                    begin
                        out_status = ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        q_ctl.push = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                ram_re = 1'b1;
            end
            S_LAST:
            begin
                ram_re = 1'b0;
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (best_found)
                    begin
                        q_ctl.pop     = 1'b1;
                        out_take_best = 1'b1;
                    end
                    else
                    begin
                        out_status = ST_EMPTY;
                    end
                end
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // command index: the pushed stream, or the scan position
    always_comb
    begin
        idx_next = idx_reg;
        if (in_fire)
        begin
            idx_next = (in_ch.func == FUNC_PUSH) ? SIDX_W'(in_ch.stream) : '0;
        end
        else if (state_reg == S_SCAN && idx_reg != SIDX_W'(STREAMS - 1))
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= (state_reg == S_SCAN) && !q_stat.empty;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (in_fire)
        begin
            range_err_reg       <= (32'(in_ch.stream) >= 32'(STREAMS));
            entry_reg.ev_time   <= in_ch.event_time;
            entry_reg.ev_target <= in_ch.event_target;
            entry_reg.ev_weight <= in_ch.event_weight;
        end
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_entry_reg  <= out_take_best ? best : '0;
            out_stream_reg <= out_take_best ? STRM_W'(best_idx) : '0;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.out_time   = out_entry_reg.ev_time;
    assign out_ch.out_target = out_entry_reg.ev_target;
    assign out_ch.out_weight = out_entry_reg.ev_weight;
    assign out_ch.out_stream = out_stream_reg;

endmodule

>>> design/ksem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksem_checker: port-level checks of the sorted event merge
// Watches the command and result channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module ksem_checker
    import ksem_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [TIME_W-1:0]   out_time,
    input logic [TARGET_W-1:0] out_target,
    input logic [WEIGHT_W-1:0] out_weight,
    input logic [STRM_W-1:0]   out_stream
);

    // one command in flight: no beat right after a taken beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("command taken while previous one still in flight");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a command in progress");

    // refused or empty results carry no event
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (out_time == '0 && out_target == '0 && out_weight == '0 &&
             out_stream == '0))
        else $error("failed result carries event data");

    // stalled result holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(out_time) &&
             $stable(out_target) && $stable(out_weight) && $stable(out_stream)))
        else $error("result changed while stalled");

endmodule

bind kway_sorted_event_merge ksem_checker u_ksem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .out_time   (out_ch.out_time),
    .out_target (out_ch.out_target),
    .out_weight (out_ch.out_weight),
    .out_stream (out_ch.out_stream)
);

>>> bench/tb_kway_sorted_event_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kway_sorted_event_merge: self-checking bench of the sorted event merge
// Sends push and pop commands over the command channel and predicts each
// result from a model of the four stream FIFOs. Results are compared field
// by field in order. Both channels idle at random, and the result channel
// is held off for a long stretch so that the merge stalls its input.
// ----------------------------------------------------------------------------
module tb_kway_sorted_event_merge;
    import ksem_pkg::*;

    localparam int NSTREAMS    = STREAMS_DEF;
    localparam int NDEPTH      = DEPTH_DEF;
    localparam int CLK_PERIOD  = 10;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              func;
        logic [STRM_W-1:0] stream;
        entry_t            ev;
    } merge_cmd_t;

    typedef struct packed {
        status_t           status;
        logic [TIME_W-1:0]   ev_time;
        logic [TARGET_W-1:0] ev_target;
        logic [WEIGHT_W-1:0] ev_weight;
        logic [STRM_W-1:0]   src;
    } merge_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ksem_in_if  cmd_ch ();
    ksem_out_if res_ch ();

    kway_sorted_event_merge #(
        .STREAMS (NSTREAMS),
        .DEPTH   (NDEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow of the stream FIFOs
    entry_t fifo_mem [NSTREAMS][NDEPTH];
    int     fifo_head [NSTREAMS];
    int     fifo_fill [NSTREAMS];

    merge_result_t expected_results [$];
    entry_t        last_pushed;

    int  errors = 0;
    int  cycle_count = 0;
    int  n_push_ok = 0, n_refused = 0, n_pop_ok = 0, n_empty = 0;
    logic tx_steady, rx_steady;
    int  hold_token;
    int  hold_seen = 0, hold_left = 0, stall_left = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic orders_first(input entry_t a, input entry_t b);
        if (a.ev_time != b.ev_time)
        begin
            return a.ev_time < b.ev_time;
        end
        return a.ev_target < b.ev_target;
    endfunction

    function automatic merge_result_t predict_merge(input merge_cmd_t cmd);
        merge_result_t r;
        logic          found;
        int            pick;
        int            s;
        entry_t        head_ev;
        entry_t        best_ev;
        r       = '0;
        r.status = ST_OK;
        found   = 1'b0;
        pick    = 0;
        best_ev = '0;
        s       = int'(cmd.stream);
        if (cmd.func == FUNC_PUSH)
        begin
            if (s >= NSTREAMS || fifo_fill[s] >= NDEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                fifo_mem[s][(fifo_head[s] + fifo_fill[s]) % NDEPTH] = cmd.ev;
                fifo_fill[s]++;
            end
            return r;
        end
        for (int i = 0; i < NSTREAMS; i++)
        begin
            if (fifo_fill[i] != 0)
            begin
                head_ev = fifo_mem[i][fifo_head[i]];
                // strict compare: a full tie keeps the lower stream
                if (!found || orders_first(head_ev, best_ev))
                begin
                    found   = 1'b1;
                    pick    = i;
                    best_ev = head_ev;
                end
            end
        end
        if (!found)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        r.ev_time   = best_ev.ev_time;
        r.ev_target = best_ev.ev_target;
        r.ev_weight = best_ev.ev_weight;
        r.src       = pick[STRM_W-1:0];
        fifo_head[pick] = (fifo_head[pick] + 1) % NDEPTH;
        fifo_fill[pick]--;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    function automatic int pick_len();
        if ($urandom_range(99) < 85)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(25, 6);
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic entry_t rand_event();
        entry_t ev;
        ev.ev_time   = rand_key();
        ev.ev_target = rand_key();
        ev.ev_weight = $urandom;
        // reuse the last key now and then to force ties across streams
        if ($urandom_range(6) == 0)
        begin
            ev.ev_time   = last_pushed.ev_time;
            ev.ev_target = last_pushed.ev_target;
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    task automatic send_cmd(input merge_cmd_t cmd);
        int gap;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.func         <= cmd.func;
        cmd_ch.stream       <= cmd.stream;
        cmd_ch.event_time   <= cmd.ev.ev_time;
        cmd_ch.event_target <= cmd.ev.ev_target;
        cmd_ch.event_weight <= cmd.ev.ev_weight;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        expected_results = {expected_results, predict_merge(cmd)};
        gap = (tx_steady || $urandom_range(1) == 0) ? 0 : pick_len();
        if (gap > 0)
        begin
            // keep valid high when the next beat follows at once
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_event(input int stream, input entry_t ev);
        merge_cmd_t cmd;
        cmd.func   = FUNC_PUSH;
        cmd.stream = stream[STRM_W-1:0];
        cmd.ev     = ev;
        last_pushed = ev;
        send_cmd(cmd);
    endtask

    task automatic pop_least();
        merge_cmd_t cmd;
        cmd.func   = FUNC_POP;
        cmd.stream = STRM_W'($urandom_range(NSTREAMS - 1));
        cmd.ev     = {$urandom, $urandom, $urandom};
        send_cmd(cmd);
    endtask

    function automatic entry_t mk_event(input logic [31:0] t, input logic [31:0] g,
                                        input logic [31:0] w);
        entry_t ev;
        ev.ev_time   = t;
        ev.ev_target = g;
        ev.ev_weight = w;
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready, long hold on request, in-order check
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_result();
        merge_result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result beat with nothing expected: status %0d time 0x%08h",
                     $time, res_ch.status, res_ch.out_time);
            errors++;
            return;
        end
        exp_r = expected_results.pop_front();
        case (exp_r.status)
            ST_FULL:  n_refused++;
            ST_EMPTY: n_empty++;
            default:  if (exp_r.src == '0 && exp_r.ev_time == '0 && exp_r.ev_target == '0
                          && exp_r.ev_weight == '0 && !res_ch.status[1]
                          && res_ch.out_time == '0 && res_ch.out_target == '0
                          && res_ch.out_weight == '0 && res_ch.out_stream == '0)
                          n_push_ok++;
                      else
                          n_pop_ok++;
        endcase
        check_field("status", 32'(exp_r.status), 32'(res_ch.status));
        check_field("out_time", exp_r.ev_time, res_ch.out_time);
        check_field("out_target", exp_r.ev_target, res_ch.out_target);
        check_field("out_weight", exp_r.ev_weight, res_ch.out_weight);
        check_field("out_stream", 32'(exp_r.src), 32'(res_ch.out_stream));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            check_result();
        end
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (rx_steady)
        begin
            res_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(3) == 0)
            begin
                stall_left = pick_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     expected_results.size());
            $display("tb_kway_sorted_event_merge: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_order();
        // empty pop, tie breaks on target then stream, extreme keys
        pop_least();
        push_event(0, mk_event(32'd5, 32'd2, 32'hFFFF_FFFF));
        push_event(1, mk_event(32'd5, 32'd2, 32'h0));
        push_event(2, mk_event(32'd5, 32'd1, 32'hA5A5_A5A5));
        push_event(3, mk_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A));
        push_event(3, mk_event(32'h0, 32'h0, 32'h1234_5678));
        pop_least();
        pop_least();
        pop_least();
        // the max-time head still blocks the zero-time event behind it
        pop_least();
        pop_least();
        pop_least();
        push_event(1, mk_event(32'h0, 32'hFFFF_FFFF, 32'h8000_0001));
        push_event(2, mk_event(32'h0, 32'hFFFF_FFFE, 32'h7FFF_FFFE));
        push_event(0, mk_event(32'h1, 32'h0, 32'hFFFF_0000));
        push_event(3, mk_event(32'hFFFF_FFFF, 32'h0, 32'h0000_FFFF));
        pop_least();
        pop_least();
        pop_least();
        pop_least();
        pop_least();
    endtask

    task automatic test_fill_and_wrap();
        // fill every stream past its depth, then wrap the pointers
        for (int s = 0; s < NSTREAMS; s++)
        begin
            repeat (NDEPTH + 1) push_event(s, rand_event());
        end
        repeat (40) pop_least();
        repeat (30) push_event($urandom_range(NSTREAMS - 1), rand_event());
        repeat (NSTREAMS * NDEPTH + 6) pop_least();
    endtask

    task automatic test_random_merge();
        int push_pct;
        for (int phase = 0; phase < 13; phase++)
        begin
            case ($urandom_range(2))
                0:       push_pct = 80;
                1:       push_pct = 50;
                default: push_pct = 20;
            endcase
            tx_steady <= ($urandom_range(3) == 0);
            rx_steady <= ($urandom_range(3) == 0);
            repeat (50)
            begin
                if ($urandom_range(99) < push_pct)
                begin
                    push_event($urandom_range(NSTREAMS - 1), rand_event());
                end
                else
                begin
                    pop_least();
                end
            end
        end
        rx_steady <= 1'b0;
    endtask

    task automatic test_input_stall();
        // hold the result side off while commands keep coming
        tx_steady  <= 1'b1;
        hold_token <= hold_token + 1;
        repeat (40)
        begin
            if ($urandom_range(1) == 0)
            begin
                push_event($urandom_range(NSTREAMS - 1), rand_event());
            end
            else
            begin
                pop_least();
            end
        end
        tx_steady <= 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.func         <= FUNC_PUSH;
        cmd_ch.stream       <= '0;
        cmd_ch.event_time   <= '0;
        cmd_ch.event_target <= '0;
        cmd_ch.event_weight <= '0;
        tx_steady   <= 1'b0;
        rx_steady   <= 1'b0;
        hold_token  <= 0;
        last_pushed = '0;
        for (int s = 0; s < NSTREAMS; s++)
        begin
            fifo_head[s] = 0;
            fifo_fill[s] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_order();
        test_fill_and_wrap();
        test_random_merge();
        test_input_stall();

        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Merge run: %0d pushes taken, %0d refused as full, %0d pops returned",
                 n_push_ok, n_refused, n_pop_ok);
        $display("an event, %0d pops found all streams empty; %0d mismatches.",
                 n_empty, errors);
        if (errors == 0)
        begin
            $display("tb_kway_sorted_event_merge: PASS");
        end
        else
        begin
            $display("tb_kway_sorted_event_merge: FAIL");
        end
        $finish;
    end

endmodule

>>> kway_sorted_event_merge.f
design/ksem_pkg.sv
design/ksem_if.sv
design/ksem_ram.sv
design/ksem_qtab.sv
design/ksem_cmp.sv
design/kway_sorted_event_merge.sv
design/ksem_checker.sv
bench/tb_kway_sorted_event_merge.sv
